// ===== hdl/tbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbbc_pkg
// Shared constants, types and schedule points of the three-band biquad cascade.
// ----------------------------------------------------------------------------
package tbbc_pkg;

    localparam int BAND_COUNT   = 3;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;

    localparam int TAP_COUNT    = 5;
    localparam int COEF_DEPTH   = BAND_COUNT * TAP_COUNT;
    localparam int COEF_AW      = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int BAND_W       = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int INDEX_WIDTH  = 4;

    localparam int COEF_FRAC    = COEF_WIDTH - 4;
    localparam int SAMPLE_FRAC  = SAMPLE_WIDTH - 1;
    localparam int STATE_WIDTH  = 48;
    localparam int STATE_FRAC   = 40;
    localparam int OUT_SHIFT    = STATE_FRAC - SAMPLE_FRAC;

    localparam int MUL_LO       = STATE_WIDTH / 2;
    localparam int PP_LO_W      = COEF_WIDTH + MUL_LO + 1;
    localparam int PP_HI_W      = COEF_WIDTH + STATE_WIDTH - MUL_LO;
    localparam int PROD_W       = COEF_WIDTH + STATE_WIDTH;
    localparam int RND_W        = PROD_W - COEF_FRAC;
    localparam int ACC_W        = RND_W + 2;
    localparam int RES_W        = STATE_WIDTH + 1 - OUT_SHIFT;

    localparam int IN_DATA_W    = ((SAMPLE_WIDTH + INDEX_WIDTH + COEF_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {3'b000, 1'b1, {COEF_FRAC{1'b0}}};
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [STATE_WIDTH:0] OUT_HALF = (STATE_WIDTH + 1)'(1) << (OUT_SHIFT - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BAND_COUNT - 1);

    // Per-band schedule, one step per cycle.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RD_LAST  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_Y        = 4'd5;
    localparam logic [STEP_W-1:0] STEP_USE_Y    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_Z1A      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_Z2A      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MUL_LAST = 4'd10;
    localparam logic [STEP_W-1:0] STEP_Z1B      = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FIN      = 4'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_x;
        logic mul_lo;
        logic mul_hi;
        logic use_y;
        logic step_y;
        logic step_z1a;
        logic step_z2a;
        logic step_z1b;
        logic step_fin;
    } t_dp_ctrl;

    typedef struct packed {
        logic               rd_en;
        logic               rd_b0;
        logic [COEF_AW-1:0] rd_addr;
    } t_coef_rd;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BAND_W-1:0] addr;
    } t_state_req;

endpackage

// ===== hdl/tbbc_coef_mem.sv =====
// ----------------------------------------------------------------------------
// tbbc_coef_mem
// Coefficient memory with one write and one registered read port. Entries not
// yet written read as pass-through coefficients: one on a b0 read, else zero.
// ----------------------------------------------------------------------------
module tbbc_coef_mem (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_wr_en,
    input  logic [tbbc_pkg::COEF_AW-1:0]              i_wr_addr,
    input  logic signed [tbbc_pkg::COEF_WIDTH-1:0]    i_wr_data,
    input  tbbc_pkg::t_coef_rd                        i_rd,
    output logic signed [tbbc_pkg::COEF_WIDTH-1:0]    o_coef
);

    logic signed [tbbc_pkg::COEF_WIDTH-1:0] r_mem [tbbc_pkg::COEF_DEPTH];
    logic [tbbc_pkg::COEF_DEPTH-1:0]        r_valid;
    logic signed [tbbc_pkg::COEF_WIDTH-1:0] r_rd_data;
    logic                                   r_rd_ok;
    logic                                   r_rd_b0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd.rd_en) begin
            r_rd_data <= r_mem[i_rd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
            r_rd_b0 <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd.rd_en) begin
                r_rd_ok <= r_valid[i_rd.rd_addr];
                r_rd_b0 <= i_rd.rd_b0;
            end
        end
    end

    always_comb begin
        if (r_rd_ok) begin
            o_coef = r_rd_data;
        end else if (r_rd_b0) begin
            o_coef = tbbc_pkg::COEF_ONE;
        end else begin
            o_coef = '0;
        end
    end

endmodule

// ===== hdl/tbbc_state_mem.sv =====
// ----------------------------------------------------------------------------
// tbbc_state_mem
// Delay-state memory holding both state words of each band in one entry.
// Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module tbbc_state_mem (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  tbbc_pkg::t_state_req                       i_req,
    input  logic signed [tbbc_pkg::STATE_WIDTH-1:0]    i_wr_z1,
    input  logic signed [tbbc_pkg::STATE_WIDTH-1:0]    i_wr_z2,
    output logic signed [tbbc_pkg::STATE_WIDTH-1:0]    o_z1,
    output logic signed [tbbc_pkg::STATE_WIDTH-1:0]    o_z2
);

    logic [2*tbbc_pkg::STATE_WIDTH-1:0] r_mem [tbbc_pkg::BAND_COUNT];
    logic [tbbc_pkg::BAND_COUNT-1:0]    r_valid;
    logic [2*tbbc_pkg::STATE_WIDTH-1:0] r_rd_data;
    logic                               r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= {i_wr_z2, i_wr_z1};
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.addr];
            end
        end
    end

    always_comb begin
        if (r_rd_ok) begin
            o_z1 = r_rd_data[tbbc_pkg::STATE_WIDTH-1:0];
            o_z2 = r_rd_data[2*tbbc_pkg::STATE_WIDTH-1:tbbc_pkg::STATE_WIDTH];
        end else begin
            o_z1 = '0;
            o_z2 = '0;
        end
    end

endmodule

// ===== hdl/tbbc_datapath.sv =====
// ----------------------------------------------------------------------------
// tbbc_datapath
// Shared two-pass multiplier, product rounding, state accumulators and the
// output rounding and saturation.
// ----------------------------------------------------------------------------
module tbbc_datapath (
    input  logic                                        i_clk,
    input  tbbc_pkg::t_dp_ctrl                          i_ctrl,
    input  logic signed [tbbc_pkg::SAMPLE_WIDTH-1:0]    i_sample,
    input  logic signed [tbbc_pkg::COEF_WIDTH-1:0]      i_coef,
    input  logic signed [tbbc_pkg::STATE_WIDTH-1:0]     i_z1,
    input  logic signed [tbbc_pkg::STATE_WIDTH-1:0]     i_z2,
    output logic signed [tbbc_pkg::STATE_WIDTH-1:0]     o_z1_new,
    output logic signed [tbbc_pkg::STATE_WIDTH-1:0]     o_z2_new,
    output logic signed [tbbc_pkg::SAMPLE_WIDTH-1:0]    o_sample,
    output logic                                        o_clip
);

    function automatic logic signed [tbbc_pkg::STATE_WIDTH-1:0] sat_state(
        input logic signed [tbbc_pkg::ACC_W-1:0] a
    );
        logic [tbbc_pkg::ACC_W-tbbc_pkg::STATE_WIDTH:0] top_bits;
        top_bits = a[tbbc_pkg::ACC_W-1:tbbc_pkg::STATE_WIDTH-1];
        if (&top_bits || ~|top_bits) begin
            sat_state = a[tbbc_pkg::STATE_WIDTH-1:0];
        end else if (a[tbbc_pkg::ACC_W-1]) begin
            sat_state = {1'b1, {(tbbc_pkg::STATE_WIDTH-1){1'b0}}};
        end else begin
            sat_state = {1'b0, {(tbbc_pkg::STATE_WIDTH-1){1'b1}}};
        end
    endfunction

    logic signed [tbbc_pkg::STATE_WIDTH-1:0]          r_x, n_x, r_y, n_y, w_src;
    logic signed [tbbc_pkg::MUL_LO:0]                 w_op_lo;
    logic signed [tbbc_pkg::STATE_WIDTH-tbbc_pkg::MUL_LO-1:0] w_op_hi;
    logic signed [tbbc_pkg::PP_LO_W-1:0]              r_pp_lo, n_pp_lo;
    logic signed [tbbc_pkg::PP_HI_W-1:0]              r_pp_hi, n_pp_hi;
    logic signed [tbbc_pkg::PROD_W-1:0]               r_full, n_full, w_rnd_sum;
    logic signed [tbbc_pkg::RND_W-1:0]                r_prod, n_prod;
    logic signed [tbbc_pkg::ACC_W-1:0]                r_acc1, n_acc1, r_acc2, n_acc2;
    logic signed [tbbc_pkg::ACC_W-1:0]                w_prod_ext, w_z1_ext, w_z2_ext;
    logic signed [tbbc_pkg::STATE_WIDTH:0]            w_out_sum;
    logic signed [tbbc_pkg::RES_W-1:0]                w_res;
    logic [tbbc_pkg::RES_W-tbbc_pkg::SAMPLE_WIDTH:0]  w_res_top;

    always_comb begin
        w_src   = i_ctrl.use_y ? r_y : r_x;
        w_op_lo = $signed({1'b0, w_src[tbbc_pkg::MUL_LO-1:0]});
        w_op_hi = w_src[tbbc_pkg::STATE_WIDTH-1:tbbc_pkg::MUL_LO];

        n_pp_lo = i_ctrl.mul_lo
                ? tbbc_pkg::PP_LO_W'(i_coef) * tbbc_pkg::PP_LO_W'(w_op_lo) : r_pp_lo;
        n_pp_hi = i_ctrl.mul_hi
                ? tbbc_pkg::PP_HI_W'(i_coef) * tbbc_pkg::PP_HI_W'(w_op_hi) : r_pp_hi;

        n_full = (tbbc_pkg::PROD_W'(r_pp_hi) <<< tbbc_pkg::MUL_LO)
               + tbbc_pkg::PROD_W'(r_pp_lo);

        // Round to nearest with ties away from zero.
        w_rnd_sum = r_full + (r_full[tbbc_pkg::PROD_W-1]
                  ? tbbc_pkg::RND_HALF - tbbc_pkg::PROD_W'(1) : tbbc_pkg::RND_HALF);
        n_prod = tbbc_pkg::RND_W'(w_rnd_sum >>> tbbc_pkg::COEF_FRAC);

        w_prod_ext = tbbc_pkg::ACC_W'(r_prod);
        w_z1_ext   = tbbc_pkg::ACC_W'(i_z1);
        w_z2_ext   = tbbc_pkg::ACC_W'(i_z2);

        n_y = i_ctrl.step_y ? sat_state(w_prod_ext + w_z1_ext) : r_y;

        if (i_ctrl.step_z1a) begin
            n_acc1 = w_z2_ext + w_prod_ext;
        end else if (i_ctrl.step_z1b) begin
            n_acc1 = r_acc1 - w_prod_ext;
        end else begin
            n_acc1 = r_acc1;
        end
        n_acc2 = i_ctrl.step_z2a ? w_prod_ext : r_acc2;

        if (i_ctrl.load_x) begin
            n_x = tbbc_pkg::STATE_WIDTH'(i_sample) <<< tbbc_pkg::OUT_SHIFT;
        end else if (i_ctrl.step_fin) begin
            n_x = r_y;
        end else begin
            n_x = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_full  <= n_full;
        r_prod  <= n_prod;
        r_acc1  <= n_acc1;
        r_acc2  <= n_acc2;
    end

    assign o_z1_new = sat_state(r_acc1);
    assign o_z2_new = sat_state(r_acc2 - w_prod_ext);

    // Output rounding with ties toward plus infinity, then saturation.
    always_comb begin
        w_out_sum = (tbbc_pkg::STATE_WIDTH + 1)'(r_x) + tbbc_pkg::OUT_HALF;
        w_res     = tbbc_pkg::RES_W'(w_out_sum >>> tbbc_pkg::OUT_SHIFT);
        w_res_top = w_res[tbbc_pkg::RES_W-1:tbbc_pkg::SAMPLE_WIDTH-1];
        if (&w_res_top || ~|w_res_top) begin
            o_sample = w_res[tbbc_pkg::SAMPLE_WIDTH-1:0];
            o_clip   = 1'b0;
        end else if (w_res[tbbc_pkg::RES_W-1]) begin
            o_sample = tbbc_pkg::SAMPLE_MIN;
            o_clip   = 1'b1;
        end else begin
            o_sample = tbbc_pkg::SAMPLE_MAX;
            o_clip   = 1'b1;
        end
    end

endmodule

// ===== hdl/tbbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbbc_ctrl
// Sequencer that walks each sample through the bands, issuing memory reads,
// multiplier passes, accumulator steps and state write-back.
// ----------------------------------------------------------------------------
module tbbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    output logic                  o_ready,
    output logic                  o_out_load,
    output tbbc_pkg::t_dp_ctrl    o_dp,
    output tbbc_pkg::t_coef_rd    o_coef_rd,
    output tbbc_pkg::t_state_req  o_state_req
);

    tbbc_pkg::t_state                r_state, n_state;
    logic [tbbc_pkg::STEP_W-1:0]     r_step, n_step;
    logic [tbbc_pkg::BAND_W-1:0]     r_band, n_band;
    logic [tbbc_pkg::COEF_AW-1:0]    r_base, n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbbc_pkg::ST_IDLE;
            r_step  <= '0;
            r_band  <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_band  <= n_band;
            r_base  <= n_base;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_band  = r_band;
        n_base  = r_base;
        case (r_state)
            tbbc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = tbbc_pkg::ST_RUN;
                    n_step  = tbbc_pkg::STEP_FIRST;
                    n_band  = '0;
                    n_base  = '0;
                end
            end
            tbbc_pkg::ST_RUN: begin
                if (r_step == tbbc_pkg::STEP_FIN) begin
                    n_step = tbbc_pkg::STEP_FIRST;
                    if (r_band == tbbc_pkg::BAND_LAST) begin
                        n_state = tbbc_pkg::ST_OUT;
                    end else begin
                        n_band = r_band + 1'b1;
                        n_base = r_base + tbbc_pkg::COEF_AW'(tbbc_pkg::TAP_COUNT);
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            tbbc_pkg::ST_OUT: begin
                if (i_out_free) begin
                    n_state = tbbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_out_load  = 1'b0;
        o_dp        = '0;
        o_coef_rd   = '0;
        o_state_req = '0;
        case (r_state)
            tbbc_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_dp.load_x = i_start;
            end
            tbbc_pkg::ST_RUN: begin
                o_coef_rd.rd_en   = !r_step[0] && (r_step <= tbbc_pkg::STEP_RD_LAST);
                o_coef_rd.rd_b0   = (r_step == tbbc_pkg::STEP_FIRST);
                o_coef_rd.rd_addr = r_base
                                  + tbbc_pkg::COEF_AW'(r_step[tbbc_pkg::STEP_W-1:1]);
                o_state_req.rd_en = (r_step == tbbc_pkg::STEP_FIRST);
                o_state_req.wr_en = (r_step == tbbc_pkg::STEP_FIN);
                o_state_req.addr  = r_band;
                o_dp.mul_lo   = r_step[0] && (r_step <= tbbc_pkg::STEP_MUL_LAST);
                o_dp.mul_hi   = !r_step[0] && (r_step != tbbc_pkg::STEP_FIRST)
                              && (r_step <= tbbc_pkg::STEP_MUL_LAST);
                o_dp.use_y    = (r_step >= tbbc_pkg::STEP_USE_Y);
                o_dp.step_y   = (r_step == tbbc_pkg::STEP_Y);
                o_dp.step_z1a = (r_step == tbbc_pkg::STEP_Z1A);
                o_dp.step_z2a = (r_step == tbbc_pkg::STEP_Z2A);
                o_dp.step_z1b = (r_step == tbbc_pkg::STEP_Z1B);
                o_dp.step_fin = (r_step == tbbc_pkg::STEP_FIN);
            end
            tbbc_pkg::ST_OUT: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/three_band_biquad_cascade.sv =====
// ----------------------------------------------------------------------------
// three_band_biquad_cascade
// Three cascaded transposed direct form II biquad sections with a writable
// coefficient memory and a saturated Q1.23 output.
// ----------------------------------------------------------------------------
// A sample transfer (tuser low) has its result offered once all three bands
// have run their schedules in turn and the output register has been loaded.
// The length of a band's schedule is set by the single multiplier that makes
// two passes for each of the five products of a band. The input is not ready
// while a sample is being filtered, so a new sample is taken only after the
// previous result has been loaded into the output register. A coefficient
// transfer (tuser high) writes one word, produces no result, and applies from the
// next sample on. After reset every band passes its input through and all
// delay state is zero.
module three_band_biquad_cascade (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_in, coef_index, coef_value, zero fill
    input  logic [tbbc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // end_of_block
    input  logic                                s_axis_tlast,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sample_out
    output logic [tbbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // end_of_block_out
    output logic                                m_axis_tlast,
    // clipped
    output logic                                m_axis_tuser
);

    localparam int IDX_LO = tbbc_pkg::SAMPLE_WIDTH;
    localparam int VAL_LO = tbbc_pkg::SAMPLE_WIDTH + tbbc_pkg::INDEX_WIDTH;

    logic                                      w_accept;
    logic                                      w_start;
    logic                                      w_coef_we;
    logic                                      w_out_free;
    logic                                      w_out_load;
    logic signed [tbbc_pkg::SAMPLE_WIDTH-1:0]  w_sample_in;
    logic [tbbc_pkg::INDEX_WIDTH-1:0]          w_index;
    logic signed [tbbc_pkg::COEF_WIDTH-1:0]    w_coef_value;
    logic signed [tbbc_pkg::COEF_WIDTH-1:0]    w_coef;
    logic signed [tbbc_pkg::STATE_WIDTH-1:0]   w_z1, w_z2, w_z1_new, w_z2_new;
    logic signed [tbbc_pkg::SAMPLE_WIDTH-1:0]  w_res_sample;
    logic                                      w_res_clip;
    tbbc_pkg::t_dp_ctrl                        w_dp;
    tbbc_pkg::t_coef_rd                        w_coef_rd;
    tbbc_pkg::t_state_req                      w_state_req;

    logic                                      r_eob, n_eob;
    logic                                      r_out_valid, n_out_valid;
    logic [tbbc_pkg::SAMPLE_WIDTH-1:0]         r_out_sample, n_out_sample;
    logic                                      r_out_last, n_out_last;
    logic                                      r_out_clip, n_out_clip;

    assign w_sample_in  = s_axis_tdata[tbbc_pkg::SAMPLE_WIDTH-1:0];
    assign w_index      = s_axis_tdata[IDX_LO +: tbbc_pkg::INDEX_WIDTH];
    assign w_coef_value = s_axis_tdata[VAL_LO +: tbbc_pkg::COEF_WIDTH];

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_start    = w_accept && !s_axis_tuser;
    assign w_coef_we  = w_accept && s_axis_tuser && (int'(w_index) < tbbc_pkg::COEF_DEPTH);
    assign w_out_free = !r_out_valid || m_axis_tready;

    tbbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_out_free  (w_out_free),
        .o_ready     (s_axis_tready),
        .o_out_load  (w_out_load),
        .o_dp        (w_dp),
        .o_coef_rd   (w_coef_rd),
        .o_state_req (w_state_req)
    );

    tbbc_coef_mem u_coef_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_coef_we),
        .i_wr_addr (tbbc_pkg::COEF_AW'(w_index)),
        .i_wr_data (w_coef_value),
        .i_rd      (w_coef_rd),
        .o_coef    (w_coef)
    );

    tbbc_state_mem u_state_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_state_req),
        .i_wr_z1 (w_z1_new),
        .i_wr_z2 (w_z2_new),
        .o_z1    (w_z1),
        .o_z2    (w_z2)
    );

    tbbc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_ctrl   (w_dp),
        .i_sample (w_sample_in),
        .i_coef   (w_coef),
        .i_z1     (w_z1),
        .i_z2     (w_z2),
        .o_z1_new (w_z1_new),
        .o_z2_new (w_z2_new),
        .o_sample (w_res_sample),
        .o_clip   (w_res_clip)
    );

    always_comb begin
        n_eob        = w_start ? s_axis_tlast : r_eob;
        n_out_sample = w_out_load ? w_res_sample : r_out_sample;
        n_out_last   = w_out_load ? r_eob : r_out_last;
        n_out_clip   = w_out_load ? w_res_clip : r_out_clip;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eob        <= n_eob;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_clip   <= n_out_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = tbbc_pkg::OUT_DATA_W'(r_out_sample);
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_clip;

endmodule

// ===== hdl/tbbc_checker.sv =====
// ----------------------------------------------------------------------------
// tbbc_checker
// Port-level checks of the three-band biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module tbbc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tbbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
         && $stable(m_axis_tuser)))
        else $error("output transfer changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // A sample transfer occupies the block in the next cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
        else $error("input ready right after a sample transfer");

    // A coefficient transfer leaves the input ready in the next cycle.
    a_coef_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> s_axis_tready)
        else $error("input not ready after a coefficient transfer");

    // A clipped result sits on one of the two rails.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[tbbc_pkg::SAMPLE_WIDTH-1:0] == tbbc_pkg::SAMPLE_MAX ||
         m_axis_tdata[tbbc_pkg::SAMPLE_WIDTH-1:0] == tbbc_pkg::SAMPLE_MIN))
        else $error("clipped flag on a sample that is not at full scale");

endmodule

bind three_band_biquad_cascade tbbc_checker u_tbbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
